// ===== sv/drum_pattern_step_sequencer_top_defines.svh =====
// assertion macros for the drum step sequencer
`ifndef DRUM_PATTERN_STEP_SEQUENCER_TOP_DEFINES_SVH
`define DRUM_PATTERN_STEP_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
`define DPSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpss check failed");
`define DPSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpss check failed");
`else
`define DPSS_ASSERT_NEXT(lbl, ante, cons)
`define DPSS_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

// ===== sv/dpss_pkg.sv =====
package dpss_pkg;

  localparam int TRACKS   = 8;
  localparam int BEATS    = 16;
  localparam int PATTERNS = 16;
  localparam int SLOTS    = 4;

  localparam int BEAT_W = 4;
  localparam int PAT_W  = 5;
  localparam int SLOT_W = 2;
  localparam int ADDR_W = 8;

  localparam logic [15:0] GATE_LEN_RST = 16'd1000;

  // command codes
  localparam logic [3:0] CMD_TICK       = 4'd0;
  localparam logic [3:0] CMD_SLOT_UP    = 4'd1;
  localparam logic [3:0] CMD_SLOT_DOWN  = 4'd2;
  localparam logic [3:0] CMD_SLOT_SET   = 4'd3;
  localparam logic [3:0] CMD_MAIN_UP    = 4'd4;
  localparam logic [3:0] CMD_MAIN_DOWN  = 4'd5;
  localparam logic [3:0] CMD_MAIN_SEL   = 4'd6;
  localparam logic [3:0] CMD_COPY       = 4'd7;
  localparam logic [3:0] CMD_PASTE      = 4'd8;
  localparam logic [3:0] CMD_RESET      = 4'd9;
  localparam logic [3:0] CMD_RUN_TOG    = 4'd10;
  localparam logic [3:0] CMD_CYCLE_TOG  = 4'd11;
  localparam logic [3:0] CMD_PAD_WRITE  = 4'd12;

  typedef struct packed {
    logic [3:0] command;
    logic       clock_level;
    logic [1:0] slot;
    logic [4:0] pattern_value;
    logic [3:0] beat;
    logic [2:0] track;
    logic       pad_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] gates;
    logic [4:0] beat_index;
    logic [4:0] current_pattern;
    logic [1:0] playlist_position;
    logic       is_running;
    logic       is_cycling;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       cap;
    logic       exec;
    logic       rd_en;
    logic       rd_pad;
    logic       rd_sweep;
    logic       pad_wr;
    logic       clip_wr;
    logic       paste_wr;
    logic       load_out;
    logic [4:0] cnt;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] command;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== sv/dpss_ctrl.sv =====
module dpss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              busy,
  input  dpss_pkg::dp_stat_t stat,
  output dpss_pkg::dp_cmd_t  cmd
);
  import dpss_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PADRD = 3'd2;
  localparam logic [2:0] S_PADWR = 3'd3;
  localparam logic [2:0] S_COPY  = 3'd4;
  localparam logic [2:0] S_PASTE = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  // sequencing of one item
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cnt_nxt  = '0;
        case (stat.command)
          CMD_PAD_WRITE: state_nxt = S_PADRD;
          CMD_COPY:      state_nxt = S_COPY;
          CMD_PASTE:     state_nxt = S_PASTE;
          default:       state_nxt = S_READ;
        endcase
      end
      S_PADRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_pad = 1'b1;
        state_nxt  = S_PADWR;
      end
      S_PADWR: begin
        cmd.pad_wr = 1'b1;
        state_nxt  = S_READ;
      end
      S_COPY: begin
        cmd.rd_en    = (cnt_r != 5'(BEATS));
        cmd.rd_sweep = 1'b1;
        cmd.clip_wr  = (cnt_r != 5'd0);
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(BEATS)) state_nxt = S_READ;
      end
      S_PASTE: begin
        cmd.paste_wr = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(BEATS - 1)) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/dpss_dp.sv =====
module dpss_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  dpss_pkg::in_item_t  in_item,
  input  logic                cfg_wr,
  input  logic [15:0]         cfg_data,
  input  dpss_pkg::dp_cmd_t   cmd,
  output dpss_pkg::dp_stat_t  stat,
  input  logic                out_stall,
  output logic                out_valid,
  output dpss_pkg::out_item_t out_item
);
  import dpss_pkg::*;

  in_item_t item_r;

  logic [15:0]       glen_r;
  logic [PAT_W-1:0]  slot_pat_r [SLOTS];
  logic [PAT_W-1:0]  pp_r, pp_nxt;
  logic [SLOT_W-1:0] pos_r, pos_nxt;
  logic [4:0]        beat_r, beat_nxt;
  logic [15:0]       pulse_r, pulse_nxt, pulse_base;
  logic              run_r, run_nxt, cyc_r, cyc_nxt, cprev_r, cprev_nxt;
  logic              gate_ok_r, gate_ok_nxt;
  logic [PAT_W-1:0]  sp_nxt [SLOTS];
  logic [PAT_W-1:0]  pv_clamp;
  logic              edge_hit;
  logic              found;
  logic [SLOT_W-1:0] np;

  logic [TRACKS-1:0] mem [1 << ADDR_W];
  logic [(1 << ADDR_W)-1:0] vld_r;
  logic [TRACKS-1:0] rdata_r;
  logic              rvld_r;
  logic [TRACKS-1:0] rd_eff;
  logic [TRACKS-1:0] clip_r [BEATS];
  logic [BEAT_W-1:0] rd_beat;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [TRACKS-1:0] wr_data;
  logic              wr_en;
  logic [PAT_W-1:0]  pp_m1;
  logic [4:0]        cnt_m1;

  logic      out_valid_r;
  out_item_t out_r;

  assign stat.command  = item_r.command;
  assign stat.out_free = !out_valid_r || !out_stall;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.cap) item_r <= in_item;
  end

  // gate length register
  always_ff @(posedge clk) begin
    if (!rst_n) glen_r <= GATE_LEN_RST;
    else if (cfg_wr) glen_r <= cfg_data;
  end

  assign pv_clamp = (item_r.pattern_value > 5'(PATTERNS)) ? 5'(PATTERNS)
                                                          : item_r.pattern_value;
  assign edge_hit = item_r.clock_level && !cprev_r;

  // next playlist slot holding a pattern
  always_comb begin
    found = 1'b0;
    np    = '0;
    for (int k = 0; k < SLOTS; k++) begin
      if (!found && (k > int'(pos_r)) && (slot_pat_r[k] != '0)) begin
        found = 1'b1;
        np    = SLOT_W'(k);
      end
    end
  end

  // command execution on the small state
  always_comb begin
    pp_nxt    = pp_r;
    pos_nxt   = pos_r;
    beat_nxt  = beat_r;
    run_nxt   = run_r;
    cyc_nxt   = cyc_r;
    cprev_nxt = cprev_r;
    for (int k = 0; k < SLOTS; k++) sp_nxt[k] = slot_pat_r[k];
    pulse_base = pulse_r;
    pulse_nxt  = pulse_r;
    case (item_r.command)
      CMD_TICK: begin
        if (run_r) begin
          if (edge_hit) begin
            pulse_base = '0;
            if (beat_r >= 5'(BEATS)) begin
              beat_nxt = '0;
            end else if (beat_r == 5'(BEATS - 1)) begin
              beat_nxt = '0;
              if (cyc_r) begin
                pos_nxt = np;
                if (slot_pat_r[np] != '0) pp_nxt = slot_pat_r[np];
              end
            end else begin
              beat_nxt = beat_r + 5'd1;
            end
          end
          cprev_nxt = item_r.clock_level;
          pulse_nxt = (pulse_base == 16'hFFFF) ? pulse_base : pulse_base + 16'd1;
        end
      end
      CMD_SLOT_UP: begin
        if (slot_pat_r[item_r.slot] < 5'(PATTERNS))
          sp_nxt[item_r.slot] = slot_pat_r[item_r.slot] + 5'd1;
      end
      CMD_SLOT_DOWN: begin
        if (slot_pat_r[item_r.slot] > 5'd1 ||
            (item_r.slot != '0 && slot_pat_r[item_r.slot] != '0))
          sp_nxt[item_r.slot] = slot_pat_r[item_r.slot] - 5'd1;
      end
      CMD_SLOT_SET: begin
        sp_nxt[item_r.slot] = (item_r.slot == '0 && pv_clamp == '0) ? 5'd1 : pv_clamp;
      end
      CMD_MAIN_UP:   if (pp_r < 5'(PATTERNS)) pp_nxt = pp_r + 5'd1;
      CMD_MAIN_DOWN: if (pp_r > 5'd1) pp_nxt = pp_r - 5'd1;
      CMD_MAIN_SEL:  pp_nxt = (pv_clamp == '0) ? 5'd1 : pv_clamp;
      CMD_RESET: begin
        beat_nxt = 5'(BEATS);
        pos_nxt  = '0;
        if (slot_pat_r[0] != '0) pp_nxt = slot_pat_r[0];
      end
      CMD_RUN_TOG:   run_nxt = !run_r;
      CMD_CYCLE_TOG: cyc_nxt = !cyc_r;
      default: ;
    endcase
    gate_ok_nxt = run_nxt && (beat_nxt < 5'(BEATS)) && (pulse_base < glen_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r    <= 5'd1;
      pos_r   <= '0;
      beat_r  <= 5'(BEATS);
      pulse_r <= '0;
      run_r   <= 1'b0;
      cyc_r   <= 1'b0;
      cprev_r <= 1'b0;
      for (int k = 0; k < SLOTS; k++) slot_pat_r[k] <= (k == 0) ? 5'd1 : 5'd0;
    end else if (cmd.exec) begin
      pp_r    <= pp_nxt;
      pos_r   <= pos_nxt;
      beat_r  <= beat_nxt;
      pulse_r <= pulse_nxt;
      run_r   <= run_nxt;
      cyc_r   <= cyc_nxt;
      cprev_r <= cprev_nxt;
      for (int k = 0; k < SLOTS; k++) slot_pat_r[k] <= sp_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) gate_ok_r <= gate_ok_nxt;
  end

  // pattern store addressing
  assign pp_m1   = pp_r - 5'd1;
  assign cnt_m1  = cmd.cnt - 5'd1;
  assign rd_beat = cmd.rd_pad   ? item_r.beat :
                   cmd.rd_sweep ? cmd.cnt[BEAT_W-1:0] : beat_r[BEAT_W-1:0];
  assign rd_addr = {pp_m1[BEAT_W-1:0], rd_beat};
  assign rd_eff  = rvld_r ? rdata_r : '0;

  always_comb begin
    wr_en   = cmd.pad_wr || cmd.paste_wr;
    wr_addr = {pp_m1[BEAT_W-1:0], cmd.cnt[BEAT_W-1:0]};
    wr_data = clip_r[cmd.cnt[BEAT_W-1:0]];
    if (cmd.pad_wr) begin
      wr_addr = {pp_m1[BEAT_W-1:0], item_r.beat};
      wr_data = rd_eff;
      wr_data[item_r.track] = item_r.pad_value;
    end
  end

  // store array and read register
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd_en) rdata_r <= mem[rd_addr];
  end

  // per-row written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rvld_r <= vld_r[rd_addr];
    end
  end

  // clipboard
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BEATS; k++) clip_r[k] <= '0;
    end else if (cmd.clip_wr) begin
      clip_r[cnt_m1[BEAT_W-1:0]] <= rd_eff;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.gates             <= gate_ok_r ? rd_eff : '0;
      out_r.beat_index        <= beat_r;
      out_r.current_pattern   <= pp_r;
      out_r.playlist_position <= pos_r;
      out_r.is_running        <= run_r;
      out_r.is_cycling        <= cyc_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== sv/drum_pattern_step_sequencer_top.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | in_item (in_item_t)
// out     | output    | out_valid / out_stall| out_item (out_item_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (gate_length)
//
// one item at a time; a pad write reads and then rewrites its row, and copy
// and paste sweep the clipboard over the beats through the single-port
// pattern store.
// rst_n is synchronous; the store reads as zero until a row is written.
// a waiting result holds in the output register; a stalled result delays
// the next item's completion only at its last step.
`include "drum_pattern_step_sequencer_top_defines.svh"

module drum_pattern_step_sequencer_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dpss_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dpss_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import dpss_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  // sequencer control
  dpss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  // state, pattern store and result register
  dpss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `DPSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DPSS_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))
  `DPSS_ASSERT_NOW(a_pattern_in_range, out_valid, out_item.current_pattern != 5'd0)

endmodule
